// File: design/rud_pkg.sv
// shared widths, payload types, controller states and command/status structs
package rud_pkg;

  localparam int DataWidth = 32;
  localparam int CntWidth  = $clog2(DataWidth);

  // one division request
  typedef struct packed {
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
  } rud_req_t;

  // one division result
  typedef struct packed {
    logic [DataWidth-1:0] quotient;
    logic [DataWidth-1:0] remainder;
    logic                 divide_by_zero;
  } rud_res_t;

  typedef enum logic {
    StIdle,
    StRun
  } rud_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic zero;
  } rud_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic divisor_zero;
  } rud_status_t;

endpackage

// File: design/restoring_unsigned_divider_top.sv
// top level of the unsigned restoring divider
// A request is taken on a clock edge with start high and busy low. A non-zero
// divisor gives one quotient bit per cycle from the shift-subtract loop: the
// request edge loads the operands, busy is high during the step cycles, and
// the result is registered on the last step. A zero divisor skips the loop: the
// result, with divide_by_zero set and quotient and remainder zero, follows in the
// cycle after the request. Each result is shown for one cycle with valid_o high
// and must be taken then; busy is already low in that cycle, so the next
// request may be given at once.
module restoring_unsigned_divider_top
  import rud_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  rud_req_t req_i,
  output logic     valid_o,
  output rud_res_t res_o
);

  rud_cmd_t    cmd;
  rud_status_t status;

  // sequencing
  rud_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // arithmetic and result register
  rud_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .valid_o  (valid_o),
    .res_o    (res_o)
  );

endmodule

// File: design/rud_ctrl.sv
// controller: sequences load, shift-subtract steps and result write
module rud_ctrl
  import rud_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  rud_status_t status_i,
  output logic        busy,
  output rud_cmd_t    cmd_o
);

  rud_state_e          state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy    = 1'b0;
    case (state_q)
      StIdle: begin
        if (start) begin
          if (status_i.divisor_zero) begin
            cmd_o.zero = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            cnt_d      = '0;
            state_d    = StRun;
          end
        end
      end
      StRun: begin
        busy       = 1'b1;
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CntWidth'(DataWidth - 1)) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// File: design/rud_dp.sv
// datapath: remainder, quotient and divisor registers, subtractor, result register
module rud_dp
  import rud_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rud_req_t    req_i,
  input  rud_cmd_t    cmd_i,
  output rud_status_t status_o,
  output logic        valid_o,
  output rud_res_t    res_o
);

  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic [DataWidth-1:0] dvs_q;
  logic [DataWidth:0]   shifted;
  logic [DataWidth+1:0] diff;
  logic                 fits;
  rud_res_t             res_q, res_d;
  logic                 valid_q;

  assign status_o.divisor_zero = (req_i.divisor == '0);

  // one restoring step: shift in next dividend bit, trial subtract
  assign shifted = {rem_q, quo_q[DataWidth-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = !diff[DataWidth+1];

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.load) begin
      rem_d = '0;
      quo_d = req_i.dividend;
    end else if (cmd_i.step) begin
      rem_d = fits ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
      quo_d = {quo_q[DataWidth-2:0], fits};
    end
  end

  // result to write on finish or zero divisor
  always_comb begin
    res_d = res_q;
    if (cmd_i.zero) begin
      res_d = '{quotient: '0, remainder: '0, divide_by_zero: 1'b1};
    end else if (cmd_i.finish) begin
      res_d = '{quotient: quo_d, remainder: rem_d, divide_by_zero: 1'b0};
    end
  end

  // working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      quo_q <= '0;
      res_q <= '0;
      dvs_q <= '0;
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      res_q <= res_d;
      if (cmd_i.load) begin
        dvs_q <= req_i.divisor;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.zero | cmd_i.finish;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: design/rud_checker.sv
// port-level checks for the divider, bound to the top level
module rud_checker
  import rud_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input rud_req_t req_i,
  input logic     valid_o,
  input rud_res_t res_o
);

  // a result never shows while a division is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy)
    else $error("result strobe while busy");

  // zero divisor request is answered next cycle with the flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.divisor == '0) |=> (valid_o && res_o.divide_by_zero))
    else $error("zero divisor not flagged next cycle");

  // non-zero divisor request starts the loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.divisor != '0) |=> busy)
    else $error("division did not start");

  // end of the loop always delivers a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> valid_o)
    else $error("loop ended without result");

  // flagged result carries zero quotient and remainder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.divide_by_zero) |-> (res_o.quotient == '0 && res_o.remainder == '0))
    else $error("divide by zero result not cleared");

endmodule

bind restoring_unsigned_divider_top rud_checker u_rud_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .req_i   (req_i),
  .valid_o (valid_o),
  .res_o   (res_o)
);

// File: dv/rud_division_monitor.sv
// division monitor: watches request and result traffic, predicts and compares results
`timescale 1ns / 1ps

module rud_division_monitor
  import rud_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  rud_req_t req_i,
  input  logic     valid_i,
  input  rud_res_t res_i,
  output int       mismatch_count_o,
  output int       pending_results_o,
  output int       results_checked_o,
  output int       zero_divides_o
);

  // expected results, oldest first
  rud_res_t expected_results[$];

  // restoring shift-subtract division with a wide partial remainder
  function automatic rud_res_t divide_restoring(input rud_req_t request);
    logic [DataWidth:0]   acc;
    logic [DataWidth-1:0] quo;
    rud_res_t             outcome;
    int                   bit_idx;
    outcome = '0;
    if (request.divisor == '0) begin
      outcome.divide_by_zero = 1'b1;
      return outcome;
    end
    acc = '0;
    quo = request.dividend;
    for (bit_idx = 0; bit_idx < DataWidth; bit_idx++) begin
      // bring in the next dividend bit, most significant first
      acc = {acc[DataWidth-1:0], quo[DataWidth-1]};
      quo = {quo[DataWidth-2:0], 1'b0};
      // keep the difference only when it does not go negative
      if (acc >= {1'b0, request.divisor}) begin
        acc    = acc - {1'b0, request.divisor};
        quo[0] = 1'b1;
      end
    end
    outcome.quotient  = quo;
    outcome.remainder = acc[DataWidth-1:0];
    return outcome;
  endfunction

  // field-by-field comparison of one result
  task automatic compare_result(input rud_res_t wanted, input rud_res_t seen);
    if (seen.quotient !== wanted.quotient) begin
      $display("%0t: quotient mismatch, expected %h, actual %h",
               $time, wanted.quotient, seen.quotient);
      mismatch_count_o++;
    end
    if (seen.remainder !== wanted.remainder) begin
      $display("%0t: remainder mismatch, expected %h, actual %h",
               $time, wanted.remainder, seen.remainder);
      mismatch_count_o++;
    end
    if (seen.divide_by_zero !== wanted.divide_by_zero) begin
      $display("%0t: divide_by_zero mismatch, expected %b, actual %b",
               $time, wanted.divide_by_zero, seen.divide_by_zero);
      mismatch_count_o++;
    end
  endtask

  initial begin
    mismatch_count_o  = 0;
    pending_results_o = 0;
    results_checked_o = 0;
    zero_divides_o    = 0;
  end

  // sample both channels on the rising edge; results are matched before new requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual q=%h r=%h dbz=%b",
                   $time, res_i.quotient, res_i.remainder, res_i.divide_by_zero);
          mismatch_count_o++;
        end else begin
          compare_result(expected_results.pop_front(), res_i);
        end
        results_checked_o++;
        if (res_i.divide_by_zero) begin
          zero_divides_o++;
        end
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(divide_restoring(req_i));
      end
      pending_results_o = expected_results.size();
    end
  end

endmodule

// File: dv/restoring_unsigned_divider_top_tb.sv
// testbench top: clock, reset, division request stimulus, watchdog and verdict
`timescale 1ns / 1ps

module restoring_unsigned_divider_top_tb
  import rud_pkg::*;
();

  localparam int RandomRequests = 900;
  localparam int MaxGap         = 40;
  localparam int IdleLimit      = 1000;
  localparam int DrainCycles    = 40;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  rud_req_t req_i;
  logic     valid_o;
  rud_res_t res_o;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int zero_divides;
  int idle_cycles;
  int requests_sent;

  restoring_unsigned_divider_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  rud_division_monitor u_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req_i),
    .valid_i          (valid_o),
    .res_i            (res_o),
    .mismatch_count_o (mismatch_count),
    .pending_results_o(pending_results),
    .results_checked_o(results_checked),
    .zero_divides_o   (zero_divides)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // watchdog on cycles where neither a request nor a result moves
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, pending_results);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one request at a falling edge and hold it until it is taken;
  // busy only moves on rising edges, so its value now decides the next edge
  task automatic issue_division(input logic [DataWidth-1:0] dividend,
                                input logic [DataWidth-1:0] divisor);
    logic taken;
    start          <= 1'b1;
    req_i.dividend <= dividend;
    req_i.divisor  <= divisor;
    taken = 1'b0;
    while (!taken) begin
      taken = !busy;
      @(negedge clk_i);
    end
    requests_sent++;
  endtask

  // divisor drawn from zero, tiny, top-half, near-dividend and full-range classes
  function automatic logic [DataWidth-1:0] pick_divisor(input logic [DataWidth-1:0] dividend);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return '0;
    if (sel < 30) return DataWidth'($urandom_range(1, 255));
    if (sel < 50) return {1'b1, (DataWidth-1)'($urandom)};
    if (sel < 60) return (dividend == '0) ? '1 : dividend - DataWidth'($urandom_range(0, 1));
    return DataWidth'($urandom);
  endfunction

  // dividend mostly full range, sometimes small or at the extremes
  function automatic logic [DataWidth-1:0] pick_dividend();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return DataWidth'($urandom_range(0, 1000));
    if (sel < 15) return '1;
    if (sel < 18) return '0;
    return DataWidth'($urandom);
  endfunction

  initial begin
    logic [DataWidth-1:0] dividend;
    int                   burst_len;
    start         = 1'b0;
    req_i         = '0;
    rst_ni        = 1'b0;
    idle_cycles   = 0;
    requests_sent = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero divisor, unit divisor, extremes and the top-half divisors
    issue_division(32'h0000_0000, 32'h0000_0000);
    issue_division(32'hFFFF_FFFF, 32'h0000_0000);
    issue_division(32'h0000_0001, 32'h0000_0000);
    issue_division(32'h0000_0000, 32'h0000_0001);
    issue_division(32'hFFFF_FFFF, 32'h0000_0001);
    issue_division(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_division(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    issue_division(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    issue_division(32'h8000_0000, 32'h8000_0000);
    issue_division(32'hFFFF_FFFF, 32'h8000_0000);
    issue_division(32'h7FFF_FFFF, 32'h8000_0000);
    issue_division(32'h1234_5678, 32'h8000_0001);
    issue_division(32'h0000_0001, 32'hFFFF_FFFF);
    issue_division(32'h0000_0000, 32'hFFFF_FFFF);
    issue_division(32'h8000_0000, 32'h0000_0001);
    issue_division(32'hFFFF_FFFF, 32'h0000_0002);
    issue_division(32'h0000_0005, 32'h0000_0007);
    issue_division(32'd123456789, 32'd1000);
    issue_division(32'hAAAA_AAAA, 32'h5555_5555);
    issue_division(32'h5555_5555, 32'hAAAA_AAAA);
    start <= 1'b0;
    repeat (5) @(negedge clk_i);

    // random bursts separated by random gaps, some bursts run back to back
    while (requests_sent < RandomRequests + 20) begin
      burst_len = $urandom_range(1, 12);
      repeat (burst_len) begin
        dividend = pick_dividend();
        issue_division(dividend, pick_divisor(dividend));
      end
      if ($urandom_range(0, 9) < 7) begin
        start <= 1'b0;
        repeat ($urandom_range(1, MaxGap)) @(negedge clk_i);
      end
    end
    start <= 1'b0;

    // drain outstanding results, then allow for a stray late result
    wait (pending_results == 0);
    repeat (DrainCycles) @(negedge clk_i);

    $display("sent %0d division requests, checked %0d results (%0d with a zero divisor)",
             requests_sent, results_checked, zero_divides);
    $display("covered full-range, small, top-half and near-equal divisors in random bursts");
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rud_pkg.sv
design/rud_ctrl.sv
design/rud_dp.sv
design/restoring_unsigned_divider_top.sv
design/rud_checker.sv
dv/rud_division_monitor.sv
dv/restoring_unsigned_divider_top_tb.sv
